>>> src/fcg_pkg.sv
// Types and constants shared by the FAT16 cluster geometry block.
// No dependencies.
package fcg_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_BYTES_PER_SECTOR   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SECTORS_PER_CLUSTER = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESERVED_SECTORS   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FAT_COPIES         = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SECTORS_PER_FAT    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROOT_ENTRY_LIMIT   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_VOLUME_SECTORS     = 3'd6;

  localparam logic [31:0] FAT16_MIN_CLUSTERS   = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT_CLUSTERS = 32'd65525;
  localparam logic [15:0] CHAIN_END_MARK       = 16'hFFF8;
  localparam int unsigned DIR_ENTRY_SHIFT      = 5;  // 32 bytes per entry

  localparam int unsigned FirstDataW = 25;
  localparam int unsigned RootW      = 22;
  localparam int unsigned OffsetW    = 29;

  // Derived volume geometry handed to the lookup pipeline
  typedef struct packed {
    logic                  busy;
    logic                  fat16;
    logic [7:0]            spc;
    logic [FirstDataW-1:0] first_data;
    logic [OffsetW-1:0]    fat_base;
  } geom_t;

endpackage

>>> src/fcg_ifs.sv
// Handshake channels of the FAT16 cluster geometry block.
// No dependencies.
interface fcg_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] cluster_number;
  modport source (output valid, output cluster_number, input ready);
  modport sink   (input valid, input cluster_number, output ready);
endinterface

interface fcg_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] cluster_first_sector;
  logic [28:0] fat_entry_byte_offset;
  logic        chain_end;
  logic        cluster_below_two;
  logic        volume_is_fat16;
  modport source (output valid, output cluster_first_sector, output fat_entry_byte_offset,
                  output chain_end, output cluster_below_two, output volume_is_fat16,
                  input ready);
  modport sink   (input valid, input cluster_first_sector, input fat_entry_byte_offset,
                  input chain_end, input cluster_below_two, input volume_is_fat16,
                  output ready);
endinterface

interface fcg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/fcg_geometry.sv
// Configuration registers and serial derivation of the volume geometry.
// Depends on fcg_pkg and fcg_ifs.
module fcg_geometry (
  input  logic           clk,
  input  logic           rst,
  fcg_cfg_if.sink        cfg,
  output fcg_pkg::geom_t geom
);
  import fcg_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_ROOT = 6'b000100,
    S_SUM  = 6'b001000,
    S_CLU  = 6'b010000,
    S_FLAG = 6'b100000
  } state_t;

  state_t state;
  logic [12:0] bps;
  logic [7:0]  spc;
  logic [15:0] rsc;
  logic [7:0]  fc;
  logic [15:0] spf;
  logic [15:0] rel;
  logic [31:0] vs;

  logic [31:0] rem, quo, dvs;
  logic [4:0]  cnt;
  logic [FirstDataW-1:0] first_data;
  logic [OffsetW-1:0]    fat_base;
  logic                  fat16;

  logic [32:0] shifted;
  logic [32:0] trial;
  logic [31:0] rem_next, quo_next;
  logic [RootW-1:0] root;
  logic [FirstDataW-1:0] fd_next;

  assign cfg.ready = 1'b1;

  // one restoring division step per cycle
  always_comb begin
    shifted = {rem, quo[31]};
    trial   = shifted - {1'b0, dvs};
    if (!trial[32]) begin
      rem_next = trial[31:0];
      quo_next = {quo[30:0], 1'b1};
    end else begin
      rem_next = shifted[31:0];
      quo_next = {quo[30:0], 1'b0};
    end
    root    = (bps == 13'd0) ? '0 : quo[RootW-1:0];
    fd_next = FirstDataW'(rsc) + FirstDataW'(fc * spf) + FirstDataW'(root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bps   <= 13'd512;
      spc   <= 8'd4;
      rsc   <= 16'd1;
      fc    <= 8'd2;
      spf   <= 16'd32;
      rel   <= 16'd512;
      vs    <= 32'd65536;
      state <= S_LOAD;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BYTES_PER_SECTOR:    bps <= cfg.data[12:0];
        REG_SECTORS_PER_CLUSTER: spc <= cfg.data[7:0];
        REG_RESERVED_SECTORS:    rsc <= cfg.data[15:0];
        REG_FAT_COPIES:          fc  <= cfg.data[7:0];
        REG_SECTORS_PER_FAT:     spf <= cfg.data[15:0];
        REG_ROOT_ENTRY_LIMIT:    rel <= cfg.data[15:0];
        REG_VOLUME_SECTORS:      vs  <= cfg.data;
        default: ;
      endcase
      state <= S_LOAD;
    end else begin
      unique case (state)
        S_IDLE: ;
        S_LOAD: begin
          rem      <= '0;
          quo      <= 32'(({16'd0, rel} << DIR_ENTRY_SHIFT) + 32'(bps) - 32'd1);
          dvs      <= 32'(bps);
          cnt      <= 5'd31;
          fat_base <= OffsetW'(rsc * bps);
          state    <= S_ROOT;
        end
        S_ROOT: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) state <= S_SUM;
        end
        S_SUM: begin
          first_data <= fd_next;
          quo   <= vs - 32'(fd_next);  // wraps when the volume is too small
          rem   <= '0;
          dvs   <= 32'(spc);
          cnt   <= 5'd31;
          state <= S_CLU;
        end
        S_CLU: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) state <= S_FLAG;
        end
        S_FLAG: begin
          fat16 <= (spc != 8'd0) && (quo >= FAT16_MIN_CLUSTERS)
                   && (quo < FAT16_LIMIT_CLUSTERS);
          state <= S_IDLE;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign geom.busy       = (state != S_IDLE);
  assign geom.fat16      = fat16;
  assign geom.spc        = spc;
  assign geom.first_data = first_data;
  assign geom.fat_base   = fat_base;

endmodule

>>> src/fcg_lookup.sv
// Three-stage cluster lookup pipeline with valid bits and back-pressure.
// Depends on fcg_pkg and fcg_ifs.
module fcg_lookup (
  input  logic           clk,
  input  logic           rst,
  input  fcg_pkg::geom_t geom,
  fcg_req_if.sink        req,
  fcg_rsp_if.source      rsp
);
  import fcg_pkg::*;

  logic v1, v2, v3;
  logic en1, en2, en3;

  logic [15:0] c1;
  logic [23:0] prod2;
  logic [OffsetW-1:0] off2;
  logic ce2, b2_2;

  logic [31:0] sector3;
  logic [OffsetW-1:0] off3;
  logic ce3, b2_3, f3;

  assign en3 = !v3 || rsp.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req.ready = en1 && !geom.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= req.valid && req.ready;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) c1 <= req.cluster_number;
    if (en2) begin
      prod2 <= (24'(c1) - 24'd2) * 24'(geom.spc);
      off2  <= geom.fat_base + OffsetW'({c1, 1'b0});
      ce2   <= (c1 >= CHAIN_END_MARK);
      b2_2  <= (c1 < 16'd2);
    end
    if (en3) begin
      sector3 <= b2_2 ? 32'd0 : 32'(geom.first_data) + 32'(prod2);
      off3    <= off2;
      ce3     <= ce2;
      b2_3    <= b2_2;
      f3      <= geom.fat16;
    end
  end

  assign rsp.valid                 = v3;
  assign rsp.cluster_first_sector  = sector3;
  assign rsp.fat_entry_byte_offset = off3;
  assign rsp.chain_end             = ce3;
  assign rsp.cluster_below_two     = b2_3;
  assign rsp.volume_is_fat16       = f3;

endmodule

>>> src/fat16_cluster_geometry.sv
// Top level of the FAT16 cluster geometry block.
// Depends on fcg_pkg, fcg_ifs, fcg_geometry and fcg_lookup.
//
//   channel  dir  word
//   req      in   cluster_number
//   rsp      out  first sector, FAT entry offset, chain end, below two, FAT16
//   cfg      in   register index, write data
//
// One lookup per cycle when rsp does not stall and the geometry is not busy.
// After reset and after each register write the geometry is rederived by a
// serial divider (two 32-step divisions); req.ready is low meanwhile.
// Reset is synchronous. A stalled rsp holds its word and the pipeline fills
// behind it without losing or repeating anything.
module fat16_cluster_geometry (
  input logic       clk,
  input logic       rst,
  fcg_req_if.sink   req,
  fcg_rsp_if.source rsp,
  fcg_cfg_if.sink   cfg
);
  import fcg_pkg::*;

  geom_t geom;

  fcg_geometry u_geometry (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .geom (geom)
  );

  fcg_lookup u_lookup (
    .clk  (clk),
    .rst  (rst),
    .geom (geom),
    .req  (req),
    .rsp  (rsp)
  );

endmodule

>>> test/fcg_checker.sv
// Checker for the FAT16 cluster geometry block: predicts each result word.
// Depends on fcg_pkg and fcg_ifs; watches req, rsp and cfg channels.
module fcg_checker (
  input  logic      clk,
  input  logic      rst,
  fcg_req_if.sink   req,
  fcg_rsp_if.sink   rsp,
  fcg_cfg_if.sink   cfg,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fcg_pkg::*;

  typedef struct packed {
    logic [31:0] first_sector;
    logic [28:0] entry_offset;
    logic        chain_end;
    logic        below_two;
    logic        fat16;
  } lookup_t;

  logic [12:0] bps;
  logic [7:0]  spc;
  logic [15:0] rsvd;
  logic [7:0]  copies;
  logic [15:0] spf;
  logic [15:0] root_ents;
  logic [31:0] vol_sectors;
  lookup_t     awaited[$];

  function automatic lookup_t lookup_cluster(input logic [15:0] cl);
    lookup_t r;
    logic [31:0] root_secs, first_data, data_secs, clusters;
    root_secs = 0;
    if (bps != 0)
      root_secs = ({16'd0, root_ents} * 32'd32 + {19'd0, bps} - 32'd1) / {19'd0, bps};
    first_data = {16'd0, rsvd} + {24'd0, copies} * {16'd0, spf} + root_secs;
    data_secs = vol_sectors - first_data;
    clusters = (spc != 0) ? data_secs / {24'd0, spc} : 32'd0;
    r.first_sector = (cl >= 2) ? ({16'd0, cl} - 32'd2) * {24'd0, spc} + first_data : 32'd0;
    r.entry_offset = 29'({16'd0, rsvd} * {19'd0, bps} + {16'd0, cl} * 32'd2);
    r.chain_end = cl >= CHAIN_END_MARK;
    r.below_two = cl < 2;
    r.fat16 = clusters >= FAT16_MIN_CLUSTERS && clusters < FAT16_LIMIT_CLUSTERS;
    return r;
  endfunction

  assign pending = awaited.size();

  always @(posedge clk) begin
    lookup_t e;
    int      n;
    n = 0;
    if (rst) begin
      bps <= 13'd512; spc <= 8'd4; rsvd <= 16'd1; copies <= 8'd2;
      spf <= 16'd32; root_ents <= 16'd512; vol_sectors <= 32'd65536;
      awaited.delete();
      errors <= 0;
    end else begin
      if (req.valid && req.ready) awaited.push_back(lookup_cluster(req.cluster_number));
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_BYTES_PER_SECTOR:    bps <= cfg.data[12:0];
          REG_SECTORS_PER_CLUSTER: spc <= cfg.data[7:0];
          REG_RESERVED_SECTORS:    rsvd <= cfg.data[15:0];
          REG_FAT_COPIES:          copies <= cfg.data[7:0];
          REG_SECTORS_PER_FAT:     spf <= cfg.data[15:0];
          REG_ROOT_ENTRY_LIMIT:    root_ents <= cfg.data[15:0];
          REG_VOLUME_SECTORS:      vol_sectors <= cfg.data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) begin
          $error("result word with nothing outstanding");
          n++;
        end else begin
          e = awaited.pop_front();
          if (rsp.cluster_first_sector !== e.first_sector) begin
            $error("cluster_first_sector exp %0d got %0d", e.first_sector,
                   rsp.cluster_first_sector);
            n++;
          end
          if (rsp.fat_entry_byte_offset !== e.entry_offset) begin
            $error("fat_entry_byte_offset exp %0d got %0d", e.entry_offset,
                   rsp.fat_entry_byte_offset);
            n++;
          end
          if (rsp.chain_end !== e.chain_end) begin
            $error("chain_end exp %0b got %0b", e.chain_end, rsp.chain_end);
            n++;
          end
          if (rsp.cluster_below_two !== e.below_two) begin
            $error("cluster_below_two exp %0b got %0b", e.below_two, rsp.cluster_below_two);
            n++;
          end
          if (rsp.volume_is_fat16 !== e.fat16) begin
            $error("volume_is_fat16 exp %0b got %0b", e.fat16, rsp.volume_is_fat16);
            n++;
          end
        end
      end
      errors <= errors + n;
    end
  end
endmodule

>>> test/tb_fat16_cluster_geometry.sv
// Testbench top for fat16_cluster_geometry: stimulus, config phases, verdict.
// Depends on fcg_pkg, fcg_ifs, fcg_checker and the block itself.
module tb_fat16_cluster_geometry;
  timeunit 1ns;
  timeprecision 1ps;
  import fcg_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   errors, pending;
  bit   hold_off = 0;

  fcg_req_if req();
  fcg_rsp_if rsp();
  fcg_cfg_if cfg();

  fat16_cluster_geometry u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));
  fcg_checker u_chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
                     .errors(errors), .pending(pending));

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    req.valid = 0; req.cluster_number = 0;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    rsp.ready = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst || hold_off) rsp.ready <= 0;
    else rsp.ready <= ($urandom_range(0, 99) < 70);
  end

  // valid stays up after the last word; drain, or a next send with a gap, drops it
  task automatic send_cluster(input logic [15:0] cl);
    int g;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 0;
      repeat (g) @(posedge clk);
    end
    req.valid <= 1;
    req.cluster_number <= cl;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_volume(input logic [12:0] b, input logic [7:0] s, input logic [15:0] r,
                            input logic [7:0] c, input logic [15:0] f, input logic [15:0] e,
                            input logic [31:0] v);
    drain();
    write_reg(REG_BYTES_PER_SECTOR, {19'd0, b});
    write_reg(REG_SECTORS_PER_CLUSTER, {24'd0, s});
    write_reg(REG_RESERVED_SECTORS, {16'd0, r});
    write_reg(REG_FAT_COPIES, {24'd0, c});
    write_reg(REG_SECTORS_PER_FAT, {16'd0, f});
    write_reg(REG_ROOT_ENTRY_LIMIT, {16'd0, e});
    write_reg(REG_VOLUME_SECTORS, v);
    cfg.valid <= 0;
  endtask

  task automatic random_burst(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_cluster(16'($urandom_range(0, 1)));
      else if (r == 1) send_cluster(16'($urandom_range(16'hFFF8, 16'hFFFF)));
      else send_cluster(16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] edge_clusters[10] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'h5555, 16'hAAAA,
                                       16'hFFF7, 16'hFFF8, 16'hFFFE, 16'hFFFF};
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: reset geometry, then edge clusters
    foreach (edge_clusters[i]) send_cluster(edge_clusters[i]);

    // long receiver hold-off while requests keep coming
    fork
      begin
        @(posedge clk);
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      random_burst(20);
    join

    // too few sectors: data count wraps
    set_volume(13'd512, 8'd1, 16'd100, 8'd2, 16'd100, 16'd512, 32'd50);
    send_cluster(16'd2); send_cluster(16'hFFFF);
    // zero sector size and zero cluster size
    set_volume(13'd0, 8'd0, 16'd32, 8'd2, 16'd250, 16'd512, 32'd1000000);
    send_cluster(16'd2); send_cluster(16'd1000);
    // oversized sector, all fields at top
    set_volume(13'h1FFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_cluster(16'd0); send_cluster(16'hFFFF); send_cluster(16'd2);
    // FAT16 boundaries: clusters 4084, 4085, 65524, 65525 with first_data 1
    set_volume(13'd4096, 8'd1, 16'd1, 8'd0, 16'd0, 16'd0, 32'd4085);
    send_cluster(16'd2);
    set_volume(13'd4096, 8'd1, 16'd1, 8'd0, 16'd0, 16'd0, 32'd4086);
    send_cluster(16'd2);
    set_volume(13'd4096, 8'd1, 16'd1, 8'd0, 16'd0, 16'd0, 32'd65525);
    send_cluster(16'd2);
    set_volume(13'd4096, 8'd1, 16'd1, 8'd0, 16'd0, 16'd0, 32'd65526);
    send_cluster(16'd2);

    // random phases, mostly plausible volumes
    for (int p = 0; p < 10; p++) begin
      if (p % 3 == 0)
        set_volume(13'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                   16'($urandom), 16'($urandom), $urandom);
      else
        set_volume(13'd512 << $urandom_range(0, 3), 8'd1 << $urandom_range(0, 7),
                   16'($urandom_range(0, 64)), 8'($urandom_range(1, 2)),
                   16'($urandom_range(1, 256)), 16'($urandom_range(0, 1024)),
                   $urandom_range(0, 2500000));
      random_burst(48);
    end

    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
